>>> sv/lsmr_pkg.sv
package lsmr_pkg;

    localparam logic [31:0] NONE_SEEN  = 32'hFFFF_FFFF;
    localparam int          SQRT_STEPS = 16;
    localparam int          NUM_SECTORS = 3;

    localparam logic [15:0]        RST_OBSTACLE    = 16'd1000;
    localparam logic [14:0]        RST_HALF_WIDTH  = 15'd600;
    localparam logic [15:0]        RST_MAX_RANGE   = 16'd10000;
    localparam logic [15:0]        RST_MIN_RANGE   = 16'd50;
    localparam logic [14:0]        RST_LAT_MARGIN  = 15'd150;
    localparam logic signed [15:0] RST_FORE_MIN    = -16'sd500;
    localparam logic signed [15:0] RST_FORE_MAX    = 16'sd2000;

    typedef enum logic [2:0] {
        REG_OBSTACLE   = 3'd0,
        REG_HALF_WIDTH = 3'd1,
        REG_MAX_RANGE  = 3'd2,
        REG_MIN_RANGE  = 3'd3,
        REG_LAT_MARGIN = 3'd4,
        REG_FORE_MIN   = 3'd5,
        REG_FORE_MAX   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] pos_x_mm;
        logic signed [15:0] pos_y_mm;
        logic signed [15:0] pos_z_mm;
        logic               point_valid;
        logic               frame_last;
    } t_point;

    typedef struct packed {
        logic [15:0] front_range_mm;
        logic [15:0] left_range_mm;
        logic [15:0] right_range_mm;
        logic        front_blocked;
    } t_result;

    typedef struct packed {
        logic [15:0]        obstacle_distance_mm;
        logic [14:0]        front_half_width_mm;
        logic [15:0]        max_range_mm;
        logic [15:0]        min_range_mm;
        logic [14:0]        side_lateral_margin_mm;
        logic signed [15:0] side_fore_min_mm;
        logic signed [15:0] side_fore_max_mm;
    } t_cfg;

    typedef struct packed {
        logic [31:0] front_sq;
        logic [31:0] left_sq;
        logic [31:0] right_sq;
    } t_mins;

endpackage

>>> sv/lsmr_front.sv
module lsmr_front
    import lsmr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_point i_in_data,
    output logic   o_push,
    output t_mins  o_push_data,
    input  logic   i_full
);

    logic        r_s1_valid;
    logic        r_s1_last;
    logic        r_s1_pv;
    logic [31:0] r_sq_x;
    logic [31:0] r_sq_y;
    logic [31:0] r_sq_z;
    logic        r_in_front;
    logic        r_in_left;
    logic        r_in_right;
    logic [31:0] r_lo_sq;
    logic [31:0] r_hi_sq;
    logic [31:0] r_front_min;
    logic [31:0] r_left_min;
    logic [31:0] r_right_min;

    logic [15:0]        ax, ay, az;
    logic               fore_ok;
    logic signed [16:0] y_ext, m_pos, m_neg;
    logic               s1_adv;
    logic [31:0]        sq;
    logic               gate;
    logic [31:0]        n_front_min, n_left_min, n_right_min;

    always_comb begin
        ax = i_in_data.pos_x_mm[15] ? (~i_in_data.pos_x_mm + 16'd1) : i_in_data.pos_x_mm;
        ay = i_in_data.pos_y_mm[15] ? (~i_in_data.pos_y_mm + 16'd1) : i_in_data.pos_y_mm;
        az = i_in_data.pos_z_mm[15] ? (~i_in_data.pos_z_mm + 16'd1) : i_in_data.pos_z_mm;
        fore_ok = (i_in_data.pos_x_mm > i_cfg.side_fore_min_mm) &&
                  (i_in_data.pos_x_mm < i_cfg.side_fore_max_mm);
        y_ext = {i_in_data.pos_y_mm[15], i_in_data.pos_y_mm};
        m_pos = $signed({2'b00, i_cfg.side_lateral_margin_mm});
        m_neg = -m_pos;
    end

    // a last word waits in stage one until the queue has room
    assign s1_adv     = !(r_s1_valid && r_s1_last && i_full);
    assign o_in_ready = s1_adv;

    always_comb begin
        sq   = r_sq_x + r_sq_y + r_sq_z;
        gate = r_s1_pv && (sq >= r_lo_sq) && (sq <= r_hi_sq);
        n_front_min = (gate && r_in_front && sq < r_front_min) ? sq : r_front_min;
        n_left_min  = (gate && r_in_left  && sq < r_left_min)  ? sq : r_left_min;
        n_right_min = (gate && r_in_right && sq < r_right_min) ? sq : r_right_min;
        o_push      = r_s1_valid && r_s1_last && !i_full;
        o_push_data = '{front_sq: n_front_min, left_sq: n_left_min, right_sq: n_right_min};
    end

    always_ff @(posedge i_clk) begin
        // gate limits follow config registers; the user must change them only while idle (unchecked)
        r_lo_sq <= {16'd0, i_cfg.min_range_mm} * {16'd0, i_cfg.min_range_mm};
        r_hi_sq <= {16'd0, i_cfg.max_range_mm} * {16'd0, i_cfg.max_range_mm};
        if (o_in_ready) begin
            r_s1_last  <= i_in_data.frame_last;
            r_s1_pv    <= i_in_data.point_valid;
            r_sq_x     <= {16'd0, ax} * {16'd0, ax};
            r_sq_y     <= {16'd0, ay} * {16'd0, ay};
            r_sq_z     <= {16'd0, az} * {16'd0, az};
            r_in_front <= !i_in_data.pos_x_mm[15] && (i_in_data.pos_x_mm != 16'sd0) &&
                          ({1'b0, ay} < {2'b00, i_cfg.front_half_width_mm});
            r_in_left  <= fore_ok && (y_ext > m_pos);
            r_in_right <= fore_ok && (y_ext < m_neg);
        end
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_front_min <= NONE_SEEN;
            r_left_min  <= NONE_SEEN;
            r_right_min <= NONE_SEEN;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (r_s1_valid && s1_adv) begin
                if (r_s1_last) begin
                    r_front_min <= NONE_SEEN;
                    r_left_min  <= NONE_SEEN;
                    r_right_min <= NONE_SEEN;
                end else begin
                    r_front_min <= n_front_min;
                    r_left_min  <= n_left_min;
                    r_right_min <= n_right_min;
                end
            end
        end
    end

endmodule

>>> sv/lsmr_fifo.sv
module lsmr_fifo
    import lsmr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_mins i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_mins o_head,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_mins         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> sv/lsmr_back.sv
module lsmr_back
    import lsmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_mins   i_head,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    localparam logic [31:0] TOP_BIT  = 32'h4000_0000;
    localparam logic [3:0]  LAST_STEP = 4'(SQRT_STEPS - 1);
    localparam logic [1:0]  LAST_SEC  = 2'(NUM_SECTORS - 1);

    t_state      r_state;
    logic [31:0] r_rem;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic [3:0]  r_step;
    logic [1:0]  r_sec;
    logic [31:0] r_q1, r_q2;
    logic        r_none_cur, r_none_q1, r_none_q2;
    logic        r_front_none;
    logic [15:0] r_rt_front, r_rt_left, r_rt_right;
    logic        r_out_valid;
    t_result     r_out_data;

    logic [31:0] trial;
    logic        ge;
    logic [31:0] n_res;
    logic [15:0] root;
    logic        out_free;

    always_comb begin
        trial    = r_res + r_bit;
        ge       = (r_rem >= trial);
        n_res    = ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        root     = r_none_cur ? i_cfg.max_range_mm : n_res[15:0];
        out_free = !r_out_valid || i_out_ready;
        o_pop    = (r_state == S_IDLE) && !i_empty;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_rem        <= i_head.front_sq;
                        r_q1         <= i_head.left_sq;
                        r_q2         <= i_head.right_sq;
                        r_none_cur   <= (i_head.front_sq == NONE_SEEN);
                        r_none_q1    <= (i_head.left_sq == NONE_SEEN);
                        r_none_q2    <= (i_head.right_sq == NONE_SEEN);
                        r_front_none <= (i_head.front_sq == NONE_SEEN);
                        r_res        <= '0;
                        r_bit        <= TOP_BIT;
                        r_step       <= '0;
                        r_sec        <= '0;
                        r_state      <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == LAST_STEP) begin
                        // roots shift in from the right sector end
                        r_rt_right <= root;
                        r_rt_left  <= r_rt_right;
                        r_rt_front <= r_rt_left;
                        r_rem      <= r_q1;
                        r_q1       <= r_q2;
                        r_none_cur <= r_none_q1;
                        r_none_q1  <= r_none_q2;
                        r_res      <= '0;
                        r_bit      <= TOP_BIT;
                        r_step     <= '0;
                        r_sec      <= r_sec + 2'd1;
                        if (r_sec == LAST_SEC) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        if (ge) begin
                            r_rem <= r_rem - trial;
                        end
                        r_res  <= n_res;
                        r_bit  <= r_bit >> 2;
                        r_step <= r_step + 4'd1;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        // floor root below obstacle distance is the same test as the square
                        r_out_data <= '{front_range_mm: r_rt_front,
                                        left_range_mm:  r_rt_left,
                                        right_range_mm: r_rt_right,
                                        front_blocked:  !r_front_none &&
                                            (r_rt_front < i_cfg.obstacle_distance_mm)};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/lidar_sector_min_range.sv
// the point pipeline registers each point's squares, then one shared square root unit
// takes 16 steps for each of three sectors and then loads the output register
// throughput: one point a cycle unless a frame's last point waits for room in the queue;
// the frame queue holds QUEUE_DEPTH frames while the root unit is busy
// reset: synchronous, active low; registers return to their defaults, minima to none seen,
// queue and output empty
module lidar_sector_min_range
    import lsmr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_point      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     push, full, pop, empty;
    t_mins    push_data, head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_distance_mm   <= RST_OBSTACLE;
            r_cfg.front_half_width_mm    <= RST_HALF_WIDTH;
            r_cfg.max_range_mm           <= RST_MAX_RANGE;
            r_cfg.min_range_mm           <= RST_MIN_RANGE;
            r_cfg.side_lateral_margin_mm <= RST_LAT_MARGIN;
            r_cfg.side_fore_min_mm       <= RST_FORE_MIN;
            r_cfg.side_fore_max_mm       <= RST_FORE_MAX;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OBSTACLE:   r_cfg.obstacle_distance_mm   <= pwdata[15:0];
                REG_HALF_WIDTH: r_cfg.front_half_width_mm    <= pwdata[14:0];
                REG_MAX_RANGE:  r_cfg.max_range_mm           <= pwdata[15:0];
                REG_MIN_RANGE:  r_cfg.min_range_mm           <= pwdata[15:0];
                REG_LAT_MARGIN: r_cfg.side_lateral_margin_mm <= pwdata[14:0];
                REG_FORE_MIN:   r_cfg.side_fore_min_mm       <= $signed(pwdata[15:0]);
                REG_FORE_MAX:   r_cfg.side_fore_max_mm       <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OBSTACLE:   prdata = {16'd0, r_cfg.obstacle_distance_mm};
            REG_HALF_WIDTH: prdata = {17'd0, r_cfg.front_half_width_mm};
            REG_MAX_RANGE:  prdata = {16'd0, r_cfg.max_range_mm};
            REG_MIN_RANGE:  prdata = {16'd0, r_cfg.min_range_mm};
            REG_LAT_MARGIN: prdata = {17'd0, r_cfg.side_lateral_margin_mm};
            REG_FORE_MIN:   prdata = {16'd0, r_cfg.side_fore_min_mm};
            REG_FORE_MAX:   prdata = {16'd0, r_cfg.side_fore_max_mm};
            default:        prdata = '0;
        endcase
    end

    lsmr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    lsmr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty)
    );

    lsmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/lsmr_checker.sv
module lsmr_checker
    import lsmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_result     o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_prdata_narrow: assert property (@(posedge i_clk)
        pready && (prdata[31:16] == 16'd0))
        else $error("register read wider than 16 bits");

    // obstacle distance reads back what was just written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && psel && penable && pwrite && paddr == 5'd0)
        ##1 (psel && !pwrite && paddr == 5'd0)
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("obstacle distance readback mismatch");

endmodule

bind lidar_sector_min_range lsmr_checker u_lsmr_checker (.*);

>>> dv/lsmr_checker.sv
`timescale 1ns / 1ps

module lsmr_scoreboard
    import lsmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_point      i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_faults,
    output int          o_pending
);

    t_cfg    cfg;
    t_mins   mins;
    t_result frames_due[$];
    t_result want;
    t_result got;
    int      fault_count = 0;

    function automatic logic [31:0] floor_root(logic [31:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= {32'd0, v}) r = trial;
        end
        return r[31:0];
    endfunction

    function automatic logic [15:0] range_of_sector(logic [31:0] sq);
        logic [31:0] root;
        if (sq == NONE_SEEN) return cfg.max_range_mm;
        root = floor_root(sq);
        return root[15:0];
    endfunction

    // folds one point into the sector minima; returns 1 when it closes a frame
    function automatic bit fold_point(t_point pt, output t_result res);
        int          x, y, z, fore_lo, fore_hi, margin;
        logic [31:0] ax, ay, az, sq, lo, hi;
        bit          fore_ok;
        x = int'(pt.pos_x_mm);
        y = int'(pt.pos_y_mm);
        z = int'(pt.pos_z_mm);
        fore_lo = int'(cfg.side_fore_min_mm);
        fore_hi = int'(cfg.side_fore_max_mm);
        margin = int'(cfg.side_lateral_margin_mm);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        sq = ax * ax + ay * ay + az * az;
        lo = 32'(cfg.min_range_mm) * 32'(cfg.min_range_mm);
        hi = 32'(cfg.max_range_mm) * 32'(cfg.max_range_mm);
        if (pt.point_valid && sq >= lo && sq <= hi) begin
            fore_ok = (x > fore_lo) && (x < fore_hi);
            if (x > 0 && ay < 32'(cfg.front_half_width_mm) && sq < mins.front_sq)
                mins.front_sq = sq;
            if (y > margin && fore_ok && sq < mins.left_sq)
                mins.left_sq = sq;
            if (y < -margin && fore_ok && sq < mins.right_sq)
                mins.right_sq = sq;
        end
        res = '0;
        if (!pt.frame_last) return 1'b0;
        res.front_range_mm = range_of_sector(mins.front_sq);
        res.left_range_mm  = range_of_sector(mins.left_sq);
        res.right_range_mm = range_of_sector(mins.right_sq);
        res.front_blocked  = (mins.front_sq != NONE_SEEN) &&
            (mins.front_sq < 32'(cfg.obstacle_distance_mm) * 32'(cfg.obstacle_distance_mm));
        mins = '1;
        return 1'b1;
    endfunction

    function automatic int field_bad(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v === exp_v) return 0;
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.obstacle_distance_mm   = RST_OBSTACLE;
            cfg.front_half_width_mm    = RST_HALF_WIDTH;
            cfg.max_range_mm           = RST_MAX_RANGE;
            cfg.min_range_mm           = RST_MIN_RANGE;
            cfg.side_lateral_margin_mm = RST_LAT_MARGIN;
            cfg.side_fore_min_mm       = RST_FORE_MIN;
            cfg.side_fore_max_mm       = RST_FORE_MAX;
            mins = '1;
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_OBSTACLE:   cfg.obstacle_distance_mm   = i_pwdata[15:0];
                    REG_HALF_WIDTH: cfg.front_half_width_mm    = i_pwdata[14:0];
                    REG_MAX_RANGE:  cfg.max_range_mm           = i_pwdata[15:0];
                    REG_MIN_RANGE:  cfg.min_range_mm           = i_pwdata[15:0];
                    REG_LAT_MARGIN: cfg.side_lateral_margin_mm = i_pwdata[14:0];
                    REG_FORE_MIN:   cfg.side_fore_min_mm       = i_pwdata[15:0];
                    REG_FORE_MAX:   cfg.side_fore_max_mm       = i_pwdata[15:0];
                    default: ;
                endcase
            end
            // output side first so a word cannot be matched against its own point
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (frames_due.size() == 0) begin
                    $error("result word with none expected: front %0d left %0d right %0d",
                           got.front_range_mm, got.left_range_mm, got.right_range_mm);
                    fault_count++;
                end else begin
                    want = frames_due.pop_front();
                    fault_count += field_bad("front_range_mm", want.front_range_mm,
                                             got.front_range_mm);
                    fault_count += field_bad("left_range_mm", want.left_range_mm,
                                             got.left_range_mm);
                    fault_count += field_bad("right_range_mm", want.right_range_mm,
                                             got.right_range_mm);
                    fault_count += field_bad("front_blocked", 16'(want.front_blocked),
                                             16'(got.front_blocked));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (fold_point(i_in_data, want)) frames_due = {frames_due, want};
            end
        end
        o_faults  <= fault_count;
        o_pending <= frames_due.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import lsmr_pkg::*;

    localparam int         NUM_PHASES     = 7;
    localparam int         PHASE_ITEMS    = 250;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         STALL_LIMIT    = 5000;
    localparam logic [2:0] REG_SPARE      = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_point      i_in_data = '0;
    logic        i_out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_result     o_out_data;
    logic [31:0] prdata;
    logic        pready;

    int   fault_total;
    int   results_pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   stall_cycles = 0;
    logic rx_held = 1'b0;
    t_cfg cur_cfg;
    event rx_hold_off;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    lidar_sector_min_range u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lsmr_scoreboard u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_faults    (fault_total),
        .o_pending   (results_pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !rx_held && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off so the frame queue fills and the input stalls
    initial begin
        forever begin
            @(rx_hold_off);
            @(posedge i_clk);
            rx_held <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            rx_held <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel ||
            !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_point mk_point(int x, int y, int z, bit v, bit l);
        t_point p;
        p.pos_x_mm    = 16'(x);
        p.pos_y_mm    = 16'(y);
        p.pos_z_mm    = 16'(z);
        p.point_valid = v;
        p.frame_last  = l;
        return p;
    endfunction

    // a quarter of coordinates cluster around the sector edges of the current settings
    function automatic logic [15:0] pick_coord(t_cfg c);
        int pick;
        int base;
        pick = $urandom_range(99);
        if (pick < 45) return 16'(int'($urandom_range(6000)) - 3000);
        if (pick < 70) begin
            case ($urandom_range(6))
                0: base = int'(c.front_half_width_mm);
                1: base = int'(c.side_lateral_margin_mm);
                2: base = int'(c.side_fore_min_mm);
                3: base = int'(c.side_fore_max_mm);
                4: base = int'(c.obstacle_distance_mm);
                5: base = int'(c.min_range_mm);
                default: base = int'(c.max_range_mm);
            endcase
            if ($urandom_range(1)) base = -base;
            return 16'(base + int'($urandom_range(4)) - 2);
        end
        if (pick < 92) return 16'($urandom);
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic t_point random_point(t_cfg c, bit l);
        t_point p;
        p.pos_x_mm    = pick_coord(c);
        p.pos_y_mm    = pick_coord(c);
        p.pos_z_mm    = $urandom_range(1) ? 16'(int'($urandom_range(400)) - 200)
                                          : pick_coord(c);
        p.point_valid = ($urandom_range(9) != 0);
        p.frame_last  = l;
        return p;
    endfunction

    function automatic t_cfg phase_cfg(int ph);
        t_cfg c;
        c.obstacle_distance_mm   = RST_OBSTACLE;
        c.front_half_width_mm    = RST_HALF_WIDTH;
        c.max_range_mm           = RST_MAX_RANGE;
        c.min_range_mm           = RST_MIN_RANGE;
        c.side_lateral_margin_mm = RST_LAT_MARGIN;
        c.side_fore_min_mm       = RST_FORE_MIN;
        c.side_fore_max_mm       = RST_FORE_MAX;
        case (ph)
            1: begin
                // everything wide open
                c.obstacle_distance_mm   = 16'hffff;
                c.front_half_width_mm    = 15'h7fff;
                c.max_range_mm           = 16'hffff;
                c.min_range_mm           = 16'd0;
                c.side_lateral_margin_mm = 15'd0;
                c.side_fore_min_mm       = 16'h8000;
                c.side_fore_max_mm       = 16'h7fff;
            end
            2: begin
                // min above max, every sector stays empty
                c.obstacle_distance_mm = 16'd500;
                c.max_range_mm         = 16'd2000;
                c.min_range_mm         = 16'd3000;
            end
            3: begin
                // no front box and an inverted side window
                c.obstacle_distance_mm   = 16'd0;
                c.front_half_width_mm    = 15'd0;
                c.max_range_mm           = 16'd30000;
                c.min_range_mm           = 16'd1;
                c.side_lateral_margin_mm = 15'd0;
                c.side_fore_min_mm       = 16'(1500);
                c.side_fore_max_mm       = 16'(-1500);
            end
            4, 5: begin
                c.obstacle_distance_mm   = 16'($urandom_range(4000));
                c.front_half_width_mm    = 15'($urandom_range(3000));
                c.max_range_mm           = 16'($urandom_range(12000, 1000));
                c.min_range_mm           = 16'($urandom_range(400));
                c.side_lateral_margin_mm = 15'($urandom_range(1500));
                c.side_fore_min_mm       = 16'(-int'($urandom_range(3000)));
                c.side_fore_max_mm       = 16'($urandom_range(5000));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    // upper bits carry junk to exercise the width masking
    task automatic apply_cfg(t_cfg c);
        write_reg(REG_OBSTACLE,   {16'($urandom), c.obstacle_distance_mm});
        write_reg(REG_HALF_WIDTH, {17'($urandom), c.front_half_width_mm});
        write_reg(REG_MAX_RANGE,  {16'($urandom), c.max_range_mm});
        write_reg(REG_MIN_RANGE,  {16'($urandom), c.min_range_mm});
        write_reg(REG_LAT_MARGIN, {17'($urandom), c.side_lateral_margin_mm});
        write_reg(REG_FORE_MIN,   {16'($urandom), c.side_fore_min_mm});
        write_reg(REG_FORE_MAX,   {16'($urandom), c.side_fore_max_mm});
        write_reg(REG_SPARE, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_cfg = c;
    endtask

    task automatic send_point(t_point p);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_point probes[$];
        int     sent;
        int     flen;

        // empty frame, then one point in each sector closed by a skipped point
        probes = {probes, mk_point(0, 0, 0, 1, 1)};
        probes = {probes, mk_point(999, 0, 0, 1, 0)};
        probes = {probes, mk_point(0, 151, 0, 1, 0)};
        probes = {probes, mk_point(0, -151, 0, 1, 0)};
        probes = {probes, mk_point(100, 0, 0, 0, 1)};
        // coordinate extremes fall outside the range gate
        probes = {probes, mk_point(32767, 32767, 32767, 1, 0)};
        probes = {probes, mk_point(-32768, -32768, -32768, 1, 1)};
        // range gate edges and the obstacle threshold
        probes = {probes, mk_point(50, 0, 0, 1, 1)};
        probes = {probes, mk_point(10000, 0, 0, 1, 1)};
        probes = {probes, mk_point(10001, 0, 0, 1, 1)};
        probes = {probes, mk_point(1000, 0, 0, 1, 1)};
        // front box edges
        probes = {probes, mk_point(0, 100, 0, 1, 0)};
        probes = {probes, mk_point(1, 600, 0, 1, 0)};
        probes = {probes, mk_point(1, -599, 0, 1, 1)};
        // side band edges
        probes = {probes, mk_point(-499, 150, 0, 1, 0)};
        probes = {probes, mk_point(-500, 200, 0, 1, 0)};
        probes = {probes, mk_point(2000, 151, 0, 1, 0)};
        probes = {probes, mk_point(1999, -151, 0, 1, 1)};
        // skipped near point must not count
        probes = {probes, mk_point(0, 0, -3000, 1, 0)};
        probes = {probes, mk_point(500, 0, 0, 0, 0)};
        probes = {probes, mk_point(-32768, 0, 0, 1, 1)};

        cur_cfg = phase_cfg(0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 86 : 0;
            rx_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 31 : 0;
            sent = 0;
            if (ph > 0) begin
                drain();
                apply_cfg(phase_cfg(ph));
            end else begin
                foreach (probes[k]) send_point(probes[k]);
                sent = probes.size();
            end
            if (ph == 1 || ph == 5) -> rx_hold_off;
            while (sent < PHASE_ITEMS) begin
                flen = ($urandom_range(9) == 0) ? $urandom_range(80, 20)
                                                : $urandom_range(10, 1);
                for (int k = 0; k < flen; k++) send_point(random_point(cur_cfg, k == flen - 1));
                sent += flen;
                // in phase 4 the sender waits for every outstanding word once mid-phase
                if (ph == 4 && sent >= PHASE_ITEMS / 2 && sent - flen < PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        if (fault_total == 0 && results_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/lsmr_pkg.sv
sv/lsmr_front.sv
sv/lsmr_fifo.sv
sv/lsmr_back.sv
sv/lidar_sector_min_range.sv
sv/lsmr_checker.sv
dv/lsmr_checker.sv
dv/tb.sv
